### rtl/alsc_pkg.sv
`timescale 1ns / 1ps
// Package for the AL state change sequencer: codes, register addresses and
// the structs passed between the configuration block, the step logic and the top level.
// No dependencies.
package alsc_pkg;

   // slave register addresses
   localparam logic [15:0] REG_CONTROL  = 16'h0120;
   localparam logic [15:0] REG_STATUS   = 16'h0130;
   localparam logic [15:0] REG_CODE     = 16'h0134;
   localparam logic [7:0]  STATE_NIBBLE = 8'h0F;
   localparam logic [7:0]  ACK_ERR_BIT  = 8'h10;

   localparam logic [1:0] CMD_FULL    = 2'd0;
   localparam logic [1:0] CMD_ACK     = 2'd1;
   localparam logic [1:0] CMD_OUTCOME = 2'd2;

   localparam logic [1:0] DG_RECEIVED = 2'd0;
   localparam logic [1:0] DG_TIMEOUT  = 2'd1;

   localparam logic [1:0] RQ_NONE   = 2'd0;
   localparam logic [1:0] RQ_RESEND = 2'd1;
   localparam logic [1:0] RQ_WRITE  = 2'd2;
   localparam logic [1:0] RQ_READ   = 2'd3;

   localparam logic [1:0] OUT_BUSY    = 2'd0;
   localparam logic [1:0] OUT_SUCCESS = 2'd1;
   localparam logic [1:0] OUT_FAILED  = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_CHECK     = 3'd1,
      PH_STATUS    = 3'd2,
      PH_CODE      = 3'd3,
      PH_ACK       = 3'd4,
      PH_CHECK_ACK = 3'd5,
      PH_END       = 3'd6,
      PH_ERROR     = 3'd7
   } phase_type;

   typedef struct packed {
      logic [19:0] write_timeout_ticks;
      logic [19:0] status_timeout_ticks;
      logic [3:0]  retry_limit;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic        ack_only_mode;
      logic [7:0]  target_state;
      logic [7:0]  previous_state;
      logic [7:0]  latest_state;
      logic [15:0] station;
      logic [3:0]  retries_left;
      logic        time_pending;
      logic [31:0] start_time;
      logic        error_mark;
   } seq_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  want_state;
      logic [15:0] slave_station;
      logic [7:0]  known_state;
      logic [1:0]  datagram_status;
      logic [15:0] wkc;
      logic [15:0] read_data;
      logic [31:0] sent_time;
      logic [31:0] received_time;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  request_kind;
      logic [15:0] register_address;
      logic [15:0] write_value;
      logic [15:0] target_station;
      logic [1:0]  outcome;
      logic [7:0]  slave_state;
      logic        slave_error;
      logic [15:0] al_status_code;
      logic        al_code_valid;
   } rsp_item_type;

endpackage

### rtl/alsc_csr.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the AL state change sequencer.
// Depends on alsc_pkg.
module alsc_csr import alsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   localparam logic [1:0] IDX_WRITE_TIMEOUT  = 2'd0;
   localparam logic [1:0] IDX_STATUS_TIMEOUT = 2'd1;
   localparam logic [1:0] IDX_RETRY_LIMIT    = 2'd2;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.write_timeout_ticks  <= 20'd3000;
         cfg_ff.status_timeout_ticks <= 20'd1000;
         cfg_ff.retry_limit          <= 4'd3;
      end else if (wr_en) begin
         unique case (idx)
            IDX_WRITE_TIMEOUT:  cfg_ff.write_timeout_ticks  <= csr_pwdata[19:0];
            IDX_STATUS_TIMEOUT: cfg_ff.status_timeout_ticks <= csr_pwdata[19:0];
            IDX_RETRY_LIMIT:    cfg_ff.retry_limit          <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         IDX_WRITE_TIMEOUT:  csr_prdata = {12'd0, cfg_ff.write_timeout_ticks};
         IDX_STATUS_TIMEOUT: csr_prdata = {12'd0, cfg_ff.status_timeout_ticks};
         IDX_RETRY_LIMIT:    csr_prdata = {28'd0, cfg_ff.retry_limit};
         default:            csr_prdata = 32'd0;
      endcase
   end

endmodule

### rtl/alsc_step.sv
`timescale 1ns / 1ps
// Step logic of the AL state change sequencer: next sequencer state and the
// result item for one accepted transfer. Depends on alsc_pkg.
module alsc_step import alsc_pkg::*; (
   input  seq_state_type cur,
   input  cfg_type       cfg,
   input  req_item_type  item,
   output seq_state_type nxt,
   output rsp_item_type  rsp
);

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_RESEND,
      ACT_WR_TARGET,
      ACT_WR_LATEST,
      ACT_ACK_CODE,
      ACT_RD_STATUS,
      ACT_RD_CODE
   } act_type;

   act_type     act;
   logic [31:0] start_eff;
   logic [31:0] elapsed;
   logic        wto_hit;
   logic        sto_hit;
   logic        wc_one;
   logic [7:0]  data_state;

   assign start_eff  = cur.time_pending ? item.sent_time : cur.start_time;
   assign elapsed    = item.received_time - start_eff;
   assign wto_hit    = elapsed >= {12'd0, cfg.write_timeout_ticks};
   assign sto_hit    = elapsed >= {12'd0, cfg.status_timeout_ticks};
   assign wc_one     = item.wkc == 16'd1;
   assign data_state = item.read_data[7:0];

   // next state
   always_comb begin
      nxt = cur;
      act = ACT_NONE;
      if (item.command == CMD_FULL || item.command == CMD_ACK) begin
         nxt.station        = item.slave_station;
         nxt.latest_state   = item.known_state;
         nxt.previous_state = item.known_state;
         nxt.error_mark     = 1'b0;
         if (item.command == CMD_FULL) begin
            nxt.ack_only_mode = 1'b0;
            nxt.target_state  = item.want_state;
            nxt.time_pending  = 1'b1;
            nxt.phase         = PH_CHECK;
            act               = ACT_WR_TARGET;
         end else begin
            nxt.ack_only_mode = 1'b1;
            nxt.target_state  = 8'd0;
            nxt.phase         = PH_ACK;
            act               = ACT_WR_LATEST;
         end
      end else if (item.command == CMD_OUTCOME && cur.phase != PH_IDLE &&
                   cur.phase != PH_END && cur.phase != PH_ERROR) begin
         if (item.datagram_status == DG_TIMEOUT && cur.retries_left != 4'd0) begin
            nxt.retries_left = cur.retries_left - 4'd1;
            act              = ACT_RESEND;
         end else if (item.datagram_status != DG_RECEIVED) begin
            nxt.phase = PH_ERROR;
         end else begin
            unique case (cur.phase)
               PH_CHECK: begin
                  nxt.time_pending = 1'b0;
                  nxt.start_time   = start_eff;
                  if (item.wkc == 16'd0) begin
                     if (wto_hit) nxt.phase = PH_ERROR;
                     else act = ACT_WR_TARGET;
                  end else if (!wc_one) begin
                     nxt.phase = PH_ERROR;
                  end else begin
                     nxt.time_pending = 1'b1;
                     nxt.phase        = PH_STATUS;
                     act              = ACT_RD_STATUS;
                  end
               end
               PH_STATUS: begin
                  if (!wc_one) begin
                     nxt.phase = PH_ERROR;
                  end else begin
                     nxt.time_pending = 1'b0;
                     nxt.start_time   = start_eff;
                     nxt.latest_state = data_state;
                     if (data_state == cur.target_state) begin
                        nxt.phase = PH_END;
                     end else if (data_state != cur.previous_state) begin
                        // new low nibble: spontaneous change, taken as the new old state; else a refusal
                        if ((data_state & STATE_NIBBLE) !=
                            (cur.previous_state & STATE_NIBBLE)) begin
                           nxt.previous_state = data_state;
                           act                = ACT_RD_STATUS;
                        end else begin
                           nxt.error_mark = 1'b1;
                           nxt.phase      = PH_CODE;
                           act            = ACT_RD_CODE;
                        end
                     end else if (sto_hit) begin
                        nxt.phase = PH_ERROR;
                     end else begin
                        act = ACT_RD_STATUS;
                     end
                  end
               end
               PH_CODE: begin
                  // acknowledge goes ahead even if the code read failed
                  nxt.phase = PH_ACK;
                  act       = wc_one ? ACT_ACK_CODE : ACT_WR_LATEST;
               end
               PH_ACK: begin
                  if (!wc_one) begin
                     nxt.phase = PH_ERROR;
                  end else begin
                     nxt.time_pending = 1'b1;
                     nxt.phase        = PH_CHECK_ACK;
                     act              = ACT_RD_STATUS;
                  end
               end
               PH_CHECK_ACK: begin
                  if (!wc_one) begin
                     nxt.phase = PH_ERROR;
                  end else begin
                     nxt.time_pending = 1'b0;
                     nxt.start_time   = start_eff;
                     nxt.latest_state = data_state;
                     if ((data_state & ACK_ERR_BIT) == 8'd0) begin
                        nxt.phase = cur.ack_only_mode ? PH_END : PH_ERROR;
                     end else if (sto_hit) begin
                        nxt.phase = PH_ERROR;
                     end else begin
                        act = ACT_RD_STATUS;
                     end
                  end
               end
               PH_IDLE, PH_END, PH_ERROR: ;
            endcase
         end
      end
      // a fresh request restores the resend budget
      if (act != ACT_NONE && act != ACT_RESEND) begin
         nxt.retries_left = cfg.retry_limit;
      end
   end

   // result item
   always_comb begin
      rsp.request_kind     = RQ_NONE;
      rsp.register_address = 16'd0;
      rsp.write_value      = 16'd0;
      rsp.al_status_code   = 16'd0;
      rsp.al_code_valid    = 1'b0;
      unique case (act)
         ACT_NONE: ;
         ACT_RESEND: rsp.request_kind = RQ_RESEND;
         ACT_WR_TARGET: begin
            rsp.request_kind     = RQ_WRITE;
            rsp.register_address = REG_CONTROL;
            rsp.write_value      = {8'd0, nxt.target_state};
         end
         ACT_WR_LATEST: begin
            rsp.request_kind     = RQ_WRITE;
            rsp.register_address = REG_CONTROL;
            rsp.write_value      = {8'd0, nxt.latest_state};
         end
         ACT_ACK_CODE: begin
            rsp.request_kind     = RQ_WRITE;
            rsp.register_address = REG_CONTROL;
            rsp.write_value      = {8'd0, nxt.latest_state};
            rsp.al_status_code   = item.read_data;
            rsp.al_code_valid    = 1'b1;
         end
         ACT_RD_STATUS: begin
            rsp.request_kind     = RQ_READ;
            rsp.register_address = REG_STATUS;
         end
         ACT_RD_CODE: begin
            rsp.request_kind     = RQ_READ;
            rsp.register_address = REG_CODE;
         end
         default: ;
      endcase
      rsp.target_station = nxt.station;
      rsp.slave_state    = nxt.latest_state;
      rsp.slave_error    = nxt.error_mark;
      if (nxt.phase == PH_END)        rsp.outcome = OUT_SUCCESS;
      else if (nxt.phase == PH_ERROR) rsp.outcome = OUT_FAILED;
      else                            rsp.outcome = OUT_BUSY;
   end

endmodule

### rtl/al_state_change_sequencer.sv
`timescale 1ns / 1ps
// Top level of the AL state change sequencer. Depends on alsc_pkg, alsc_csr and alsc_step.
//
// Each accepted req_ transfer (a start command or one datagram outcome) yields
// exactly one rsp_ transfer that names the next datagram to issue and the
// progress of the change. The step logic sits between the sequencer state
// registers and a single result register, so a transfer is accepted every
// cycle while the result register is empty or being drained; the result is offered in
// the cycle after acceptance. Timeout checks compare received_time against the send time
// of the first datagram of a polling phase, modulo 2^32. The user must write configuration
// through the csr_ port while no transfer is in flight; the block does not enforce this.
module al_state_change_sequencer import alsc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] target state, [23:8] station address, [31:24] known slave state,
   // [33:32] datagram_status, [49:34] working count, [65:50] read_data,
   // [97:66] sent_time, [129:98] received_time, [135:130] zero
   input  logic [135:0] req_tdata,
   // [1:0] command
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] register_address, [31:16] write_value, [47:32] target_station,
   // [49:48] outcome, [57:50] slave_state, [58] slave_error,
   // [74:59] al_status_code, [75] al_code_valid, [79:76] zero
   output logic [79:0]  rsp_tdata,
   // [1:0] request_kind
   output logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type       cfg;
   req_item_type  item;
   seq_state_type state_ff;
   seq_state_type state_in;
   rsp_item_type  rsp_in;
   rsp_item_type  rsp_ff;
   logic          rsp_valid_ff;
   logic          accept;

   alsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign item.command         = req_tuser;
   assign item.want_state      = req_tdata[7:0];
   assign item.slave_station   = req_tdata[23:8];
   assign item.known_state     = req_tdata[31:24];
   assign item.datagram_status = req_tdata[33:32];
   assign item.wkc             = req_tdata[49:34];
   assign item.read_data       = req_tdata[65:50];
   assign item.sent_time       = req_tdata[97:66];
   assign item.received_time   = req_tdata[129:98];

   alsc_step u_step (
      .cur  (state_ff),
      .cfg  (cfg),
      .item (item),
      .nxt  (state_in),
      .rsp  (rsp_in)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.request_kind;
   assign rsp_tdata  = {4'd0, rsp_ff.al_code_valid, rsp_ff.al_status_code,
                        rsp_ff.slave_error, rsp_ff.slave_state, rsp_ff.outcome,
                        rsp_ff.target_station, rsp_ff.write_value,
                        rsp_ff.register_address};

`ifndef SYNTHESIS
   // a finished sequence never asks for another datagram
   a_done_no_request: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.outcome != OUT_BUSY |-> rsp_ff.request_kind == RQ_NONE)
      else $error("request issued with a finished outcome");

   // a code is only reported together with the acknowledge write
   a_code_with_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.al_code_valid |->
         rsp_ff.request_kind == RQ_WRITE && rsp_ff.register_address == REG_CONTROL)
      else $error("status code reported without acknowledge write");

   // the station follows the last start command
   a_station_from_start: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == CMD_FULL || req_tuser == CMD_ACK) |=>
         rsp_ff.target_station == $past(req_tdata[23:8]))
      else $error("target station does not match start command");

   // no result is offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule

### tb/sv/tb_al_state_change_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for al_state_change_sequencer: directed sequences, then random
// sequences under four handshake pressure settings, checked against an in-bench model.
// Depends on alsc_pkg and the al_state_change_sequencer RTL.
module tb_al_state_change_sequencer;
   import alsc_pkg::*;

   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam logic [1:0] DG_FAILED    = 2'd2;
   localparam logic [1:0] DG_RESERVED  = 2'd3;

   localparam logic [3:0] CSR_WRITE_TIMEOUT  = 4'h0;
   localparam logic [3:0] CSR_STATUS_TIMEOUT = 4'h4;
   localparam logic [3:0] CSR_RETRY_LIMIT    = 4'h8;

   localparam int STALL_LIMIT = 5000;
   localparam int MAX_PRINTS  = 100;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [79:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // sequencer model: configuration copy and state
   logic [19:0]  cfg_write_ticks;
   logic [19:0]  cfg_status_ticks;
   logic [3:0]   cfg_retries;
   phase_type    m_phase;
   logic         m_ack_only;
   logic [7:0]   m_target;
   logic [7:0]   m_previous;
   logic [7:0]   m_latest;
   logic [15:0]  m_station;
   logic [3:0]   m_retries;
   logic         m_time_pending;
   logic [31:0]  m_start_time;
   logic         m_error;
   logic [1:0]   plan_kind;
   logic [15:0]  plan_addr;
   logic [15:0]  plan_value;
   logic [15:0]  code_word;
   logic         code_ok;

   rsp_item_type next_requests[$];

   int           sender_idle_pct;
   int           rsp_stall_pct;
   int           items_sent;
   int           active_items;
   int           results_checked;
   int           mismatch_count;
   int           stalled_cycles;
   logic [31:0]  tick_now;

   al_state_change_sequencer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- model

   function automatic void plan_request(logic [1:0] kind, logic [15:0] addr, logic [15:0] value);
      plan_kind  = kind;
      plan_addr  = addr;
      plan_value = value;
      m_retries  = cfg_retries;
   endfunction

   function automatic void start_clock(logic [31:0] sent);
      if (m_time_pending) begin
         m_time_pending = 1'b0;
         m_start_time   = sent;
      end
   endfunction

   function automatic logic timed_out(logic [31:0] received, logic [19:0] limit);
      logic [31:0] elapsed;
      elapsed = received - m_start_time;
      return elapsed >= {12'h000, limit};
   endfunction

   function automatic logic sequence_busy();
      return !(m_phase == PH_IDLE || m_phase == PH_END || m_phase == PH_ERROR);
   endfunction

   function automatic void advance_on_outcome(req_item_type it);
      if (!sequence_busy())
         return;
      if (it.datagram_status == DG_TIMEOUT && m_retries != 4'd0) begin
         m_retries = m_retries - 4'd1;
         plan_kind = RQ_RESEND;
         return;
      end
      if (it.datagram_status != DG_RECEIVED) begin
         m_phase = PH_ERROR;
         return;
      end
      case (m_phase)
         PH_CHECK: begin
            start_clock(it.sent_time);
            if (it.wkc == 16'd0) begin
               if (timed_out(it.received_time, cfg_write_ticks))
                  m_phase = PH_ERROR;
               else
                  plan_request(RQ_WRITE, REG_CONTROL, {8'h00, m_target});
            end else if (it.wkc > 16'd1) begin
               m_phase = PH_ERROR;
            end else begin
               m_time_pending = 1'b1;
               plan_request(RQ_READ, REG_STATUS, 16'h0000);
               m_phase = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (it.wkc != 16'd1) begin
               m_phase = PH_ERROR;
               return;
            end
            start_clock(it.sent_time);
            m_latest = it.read_data[7:0];
            if (m_latest == m_target) begin
               m_phase = PH_END;
            end else if (m_latest != m_previous) begin
               // a new low nibble is a spontaneous change, otherwise the slave refused
               if ((m_latest & STATE_NIBBLE) != (m_previous & STATE_NIBBLE)) begin
                  m_previous = m_latest;
                  plan_request(RQ_READ, REG_STATUS, 16'h0000);
               end else begin
                  m_error = 1'b1;
                  plan_request(RQ_READ, REG_CODE, 16'h0000);
                  m_phase = PH_CODE;
               end
            end else if (timed_out(it.received_time, cfg_status_ticks)) begin
               m_phase = PH_ERROR;
            end else begin
               plan_request(RQ_READ, REG_STATUS, 16'h0000);
            end
         end
         PH_CODE: begin
            if (it.wkc == 16'd1) begin
               code_word = it.read_data;
               code_ok   = 1'b1;
            end
            plan_request(RQ_WRITE, REG_CONTROL, {8'h00, m_latest});
            m_phase = PH_ACK;
         end
         PH_ACK: begin
            if (it.wkc != 16'd1) begin
               m_phase = PH_ERROR;
            end else begin
               m_time_pending = 1'b1;
               plan_request(RQ_READ, REG_STATUS, 16'h0000);
               m_phase = PH_CHECK_ACK;
            end
         end
         default: begin
            if (it.wkc != 16'd1) begin
               m_phase = PH_ERROR;
               return;
            end
            start_clock(it.sent_time);
            m_latest = it.read_data[7:0];
            if ((m_latest & ACK_ERR_BIT) == 8'h00)
               m_phase = m_ack_only ? PH_END : PH_ERROR;
            else if (timed_out(it.received_time, cfg_status_ticks))
               m_phase = PH_ERROR;
            else
               plan_request(RQ_READ, REG_STATUS, 16'h0000);
         end
      endcase
   endfunction

   function automatic rsp_item_type sequence_step(req_item_type it);
      rsp_item_type r;
      plan_kind  = RQ_NONE;
      plan_addr  = 16'h0000;
      plan_value = 16'h0000;
      code_word  = 16'h0000;
      code_ok    = 1'b0;
      if (it.command == CMD_FULL || it.command == CMD_ACK) begin
         m_station  = it.slave_station;
         m_latest   = it.known_state;
         m_previous = m_latest;
         m_error    = 1'b0;
         if (it.command == CMD_FULL) begin
            m_ack_only     = 1'b0;
            m_target       = it.want_state;
            m_time_pending = 1'b1;
            plan_request(RQ_WRITE, REG_CONTROL, {8'h00, m_target});
            m_phase = PH_CHECK;
         end else begin
            m_ack_only = 1'b1;
            m_target   = 8'h00;
            plan_request(RQ_WRITE, REG_CONTROL, {8'h00, m_latest});
            m_phase = PH_ACK;
         end
      end else if (it.command == CMD_OUTCOME) begin
         advance_on_outcome(it);
      end
      r.request_kind     = plan_kind;
      r.register_address = plan_addr;
      r.write_value      = plan_value;
      r.target_station   = m_station;
      r.outcome          = (m_phase == PH_END) ? OUT_SUCCESS :
                           (m_phase == PH_ERROR) ? OUT_FAILED : OUT_BUSY;
      r.slave_state      = m_latest;
      r.slave_error      = m_error;
      r.al_status_code   = code_word;
      r.al_code_valid    = code_ok;
      return r;
   endfunction

   // ------------------------------------------------------------ checking

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < MAX_PRINTS)
         $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.request_kind     = rsp_tuser;
         got.register_address = rsp_tdata[15:0];
         got.write_value      = rsp_tdata[31:16];
         got.target_station   = rsp_tdata[47:32];
         got.outcome          = rsp_tdata[49:48];
         got.slave_state      = rsp_tdata[57:50];
         got.slave_error      = rsp_tdata[58];
         got.al_status_code   = rsp_tdata[74:59];
         got.al_code_valid    = rsp_tdata[75];
         results_checked++;
         if (next_requests.size() == 0) begin
            report_mismatch("transfer with nothing expected", {30'h0, got.request_kind}, 32'h0);
         end else begin
            want = next_requests.pop_front();
            if (got.request_kind !== want.request_kind)
               report_mismatch("request_kind", got.request_kind, want.request_kind);
            if (got.register_address !== want.register_address)
               report_mismatch("register_address", got.register_address, want.register_address);
            if (got.write_value !== want.write_value)
               report_mismatch("write_value", got.write_value, want.write_value);
            if (got.target_station !== want.target_station)
               report_mismatch("target_station", got.target_station, want.target_station);
            if (got.outcome !== want.outcome)
               report_mismatch("outcome", got.outcome, want.outcome);
            if (got.slave_state !== want.slave_state)
               report_mismatch("slave_state", got.slave_state, want.slave_state);
            if (got.slave_error !== want.slave_error)
               report_mismatch("slave_error", got.slave_error, want.slave_error);
            if (got.al_status_code !== want.al_status_code)
               report_mismatch("al_status_code", got.al_status_code, want.al_status_code);
            if (got.al_code_valid !== want.al_code_valid)
               report_mismatch("al_code_valid", got.al_code_valid, want.al_code_valid);
         end
      end
   end

   // hold off the result side at random
   always @(negedge clock)
      rsp_tready = ($urandom_range(0, 99) >= rsp_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------ stimulus

   task automatic send_item(req_item_type it);
      logic ignored;
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {6'h00, it.received_time, it.sent_time, it.read_data, it.wkc,
                    it.datagram_status, it.known_state, it.slave_station,
                    it.want_state};
      req_tuser  = it.command;
      req_tvalid = 1'b1;
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      ignored = (it.command == CMD_RESERVED) || (it.command == CMD_OUTCOME && !sequence_busy());
      if (!ignored)
         active_items++;
      items_sent++;
      next_requests.push_back(sequence_step(it));
   endtask

   // drop valid and wait for every outstanding result
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (next_requests.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] addr, logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = addr;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do
         @(posedge clock);
      while (csr_pready !== 1'b1);
      case (addr)
         CSR_WRITE_TIMEOUT:  cfg_write_ticks  = value[19:0];
         CSR_STATUS_TIMEOUT: cfg_status_ticks = value[19:0];
         default:            cfg_retries      = value[3:0];
      endcase
      // read back
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do
         @(posedge clock);
      while (csr_pready !== 1'b1);
      if (csr_prdata !== value)
         report_mismatch("register read back", csr_prdata, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_config(logic [19:0] write_ticks, logic [19:0] status_ticks,
                             logic [3:0] retries);
      drain_results();
      csr_write(CSR_WRITE_TIMEOUT, {12'h000, write_ticks});
      csr_write(CSR_STATUS_TIMEOUT, {12'h000, status_ticks});
      csr_write(CSR_RETRY_LIMIT, {28'h0000000, retries});
   endtask

   function automatic req_item_type start_item(logic [1:0] cmd, logic [7:0] requested,
                                                logic [15:0] stn, logic [7:0] current);
      req_item_type it;
      it               = '0;
      it.command       = cmd;
      it.want_state    = requested;
      it.slave_station = stn;
      it.known_state   = current;
      return it;
   endfunction

   function automatic req_item_type outcome_item(logic [1:0] dg, logic [15:0] wc,
                                                 logic [15:0] data, logic [31:0] sent,
                                                 logic [31:0] received);
      req_item_type it;
      it                 = '0;
      it.command         = CMD_OUTCOME;
      it.datagram_status = dg;
      it.wkc             = wc;
      it.read_data       = data;
      it.sent_time       = sent;
      it.received_time   = received;
      return it;
   endfunction

   // fill every field with random bits
   function automatic req_item_type random_item();
      logic [159:0] bits;
      bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return bits[$bits(req_item_type)-1:0];
   endfunction

   function automatic req_item_type random_start();
      req_item_type it;
      it = random_item();
      it.command = ($urandom_range(0, 99) < 80) ? CMD_FULL : CMD_ACK;
      if ($urandom_range(0, 99) < 20)
         it.known_state = it.want_state;
      return it;
   endfunction

   function automatic req_item_type noise_item();
      req_item_type it;
      it = random_item();
      it.command = ($urandom_range(0, 1) == 0) ? CMD_RESERVED : CMD_OUTCOME;
      return it;
   endfunction

   // outcome shaped to the sequencer's current phase so that most runs go deep
   function automatic req_item_type shaped_outcome();
      req_item_type it;
      int           roll;
      logic [19:0]  lim;
      it         = random_item();
      it.command = CMD_OUTCOME;
      roll = $urandom_range(0, 99);
      it.datagram_status = (roll < 86) ? DG_RECEIVED : (roll < 94) ? DG_TIMEOUT :
                           (roll < 97) ? DG_FAILED : DG_RESERVED;
      roll = $urandom_range(0, 99);
      if (m_phase == PH_CHECK)
         it.wkc = (roll < 65) ? 16'd1 : (roll < 90) ? 16'd0 :
                  16'($urandom_range(2, 65535));
      else
         it.wkc = (roll < 88) ? 16'd1 : (roll < 94) ? 16'd0 :
                  16'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (m_phase == PH_STATUS) begin
         if (roll < 30)
            it.read_data[7:0] = m_target;
         else if (roll < 55)
            it.read_data[7:0] = m_previous;
         else if (roll < 75)
            it.read_data[7:0] = m_previous ^ {4'($urandom_range(1, 15)), 4'h0};
         else if (roll < 90)
            it.read_data[7:0] = m_previous ^ {4'($urandom()), 4'($urandom_range(1, 15))};
      end else if (m_phase == PH_CHECK_ACK) begin
         it.read_data[4] = (roll < 50);
      end
      lim = (m_phase == PH_CHECK) ? cfg_write_ticks : cfg_status_ticks;
      if ($urandom_range(0, 99) >= 3) begin
         it.sent_time     = tick_now;
         it.received_time = tick_now + $urandom_range(0, {12'h000, lim} / 4 + 1);
         if ($urandom_range(0, 99) < 80)
            tick_now = tick_now + $urandom_range(0, {12'h000, lim} / 3 + 1);
         else
            tick_now = tick_now + $urandom_range(0, {12'h000, lim} + {12'h000, lim} / 2 + 1);
      end
      return it;
   endfunction

   // ------------------------------------------------------------ tests

   task automatic test_ignored_items();
      req_item_type it;
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'hFFFF, 32'd0, 32'd0));
      it         = '1;
      it.command = CMD_RESERVED;
      send_item(it);
   endtask

   task automatic test_full_change();
      send_item(start_item(CMD_FULL, 8'h08, 16'hFFFF, 8'h02));
      send_item(outcome_item(DG_RECEIVED, 16'd0, 16'h0000, 32'd100, 32'd150));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'h0000, 32'd200, 32'd250));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'hFF02, 32'd300, 32'd350));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'hAB08, 32'd400, 32'd450));
      drain_results();
   endtask

   task automatic test_refused_change();
      send_item(start_item(CMD_FULL, 8'h04, 16'h0000, 8'h01));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'h0000, 32'd10, 32'd20));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'h0011, 32'd30, 32'd40));
      // code read fails, acknowledge goes ahead anyway
      send_item(outcome_item(DG_RECEIVED, 16'd0, 16'h001E, 32'd40, 32'd45));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'h0000, 32'd45, 32'd48));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'h0011, 32'd50, 32'd60));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'h0001, 32'd70, 32'd2000));
   endtask

   task automatic test_ack_only();
      send_item(start_item(CMD_ACK, 8'hFF, 16'hA5A5, 8'h14));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'h0000, 32'd1, 32'd2));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'h0004, 32'd3, 32'd4));
   endtask

   task automatic test_spontaneous_and_retries();
      send_item(start_item(CMD_FULL, 8'h08, 16'h1234, 8'h02));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'h0000, 32'd0, 32'd5));
      send_item(outcome_item(DG_RECEIVED, 16'd1, 16'h0004, 32'd6, 32'd9));
      // restart while busy, then run the resends out
      send_item(start_item(CMD_FULL, 8'hFF, 16'hFFFF, 8'hFF));
      repeat (4) send_item(outcome_item(DG_TIMEOUT, 16'd0, 16'h0000, 32'd0, 32'd0));
   endtask

   task automatic test_zero_timeouts();
      set_config(20'd0, 20'd0, 4'd0);
      send_item(start_item(CMD_FULL, 8'h02, 16'h0001, 8'h01));
      send_item(outcome_item(DG_RECEIVED, 16'd0, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
   endtask

   task automatic run_sequences(int quota);
      int goal;
      int steps;
      goal = active_items + quota;
      while (active_items < goal) begin
         if ($urandom_range(0, 99) < 4) begin
            send_item(noise_item());
         end else begin
            send_item(random_start());
            steps = 0;
            while (sequence_busy() && steps < 40) begin
               if ($urandom_range(0, 99) < 2)
                  send_item(random_start());
               else
                  send_item(shaped_outcome());
               steps++;
            end
            if ($urandom_range(0, 99) < 15)
               send_item(shaped_outcome());
            if ($urandom_range(0, 99) < 5)
               drain_results();
         end
      end
   endtask

   task automatic test_random_traffic();
      tick_now = $urandom();
      set_config(20'd3000, 20'd1000, 4'd3);
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      run_sequences(300);
      set_config(20'd30, 20'd20, 4'd0);
      sender_idle_pct = 75;
      run_sequences(300);
      set_config(20'hFFFFF, 20'd1000000, 4'd15);
      sender_idle_pct = 0;
      rsp_stall_pct   = 75;
      run_sequences(300);
      set_config(20'd1, 20'd7, 4'd2);
      sender_idle_pct = 25;
      rsp_stall_pct   = 25;
      run_sequences(300);
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      rsp_tready      = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      items_sent      = 0;
      active_items    = 0;
      results_checked = 0;
      mismatch_count  = 0;
      stalled_cycles  = 0;
      tick_now        = '0;
      cfg_write_ticks  = 20'd3000;
      cfg_status_ticks = 20'd1000;
      cfg_retries      = 4'd3;
      m_phase          = PH_IDLE;
      m_ack_only       = 1'b0;
      m_target         = '0;
      m_previous       = '0;
      m_latest         = '0;
      m_station        = '0;
      m_retries        = '0;
      m_time_pending   = 1'b0;
      m_start_time     = '0;
      m_error          = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_ignored_items();
      test_full_change();
      test_refused_change();
      test_ack_only();
      test_spontaneous_and_retries();
      test_zero_timeouts();
      test_random_traffic();
      drain_results();
      repeat (5) @(posedge clock);

      $display("Sent %0d items (%0d acted on), checked %0d results, %0d mismatches",
               items_sent, active_items, results_checked, mismatch_count);
      $display("Covered full and acknowledge-only changes, refusals, retries and timeouts");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
